// File: rtl/core/swm_pkg.sv
package swm_pkg;

  localparam int CoordW   = 24;
  localparam int DistW    = 48;
  localparam int ProbW    = 16;
  localparam int ChgW     = 10;
  localparam int CntW     = 9;
  localparam int RemSteps = 24;
  localparam int Lanes    = 4;

  // Lanes 0/1: x/y against the old position, lanes 2/3: x/y against the trial one
  typedef enum logic [2:0] {
    CFG_BOX_X       = 3'd0,
    CFG_BOX_Y       = 3'd1,
    CFG_CORE_DIST   = 3'd2,
    CFG_WELL_DIST   = 3'd3,
    CFG_ACCEPT_PROB = 3'd4,
    CFG_NUM_PART    = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_ORIG, S_SWEEP, S_DRAIN, S_POWER, S_OUT
  } state_t;

  typedef struct packed {
    logic                          valid;
    logic                          skip;
    logic                          last;
    logic [Lanes-1:0]              neg;
    logic [Lanes-1:0][CoordW-1:0]  r;
  } lane_t;

  typedef struct packed {
    logic valid;
    logic skip;
    logic last;
    logic ovl_b;
    logic con_b;
    logic ovl_a;
    logic con_a;
  } pair_res_t;

endpackage

// File: rtl/core/swm_rem_cell.sv
module swm_rem_cell
  import swm_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CoordW-1:0] box_x,
  input  logic [CoordW-1:0] box_y,
  input  lane_t             lane_i,
  output lane_t             lane_o
);

  localparam int WideW = CoordW + RemSteps;

  lane_t lane_r, lane_nxt;

  // One restoring remainder step: drop box<<SHIFT where it fits
  always_comb begin
    logic [WideW-1:0] sub;
    logic [CoordW-1:0] bx;
    lane_nxt = lane_i;
    for (int l = 0; l < Lanes; l++) begin
      bx  = (l % 2 == 1) ? box_y : box_x;
      sub = WideW'(bx) << SHIFT;
      if (sub <= WideW'(lane_i.r[l])) begin
        lane_nxt.r[l] = lane_i.r[l] - sub[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end
  end

  assign lane_o = lane_r;

endmodule

// File: rtl/core/swm_dist_cell.sv
module swm_dist_cell
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CoordW-1:0] box_x,
  input  logic [CoordW-1:0] box_y,
  input  logic [DistW-1:0]  core_dist_sq,
  input  logic [DistW-1:0]  well_dist_sq,
  input  lane_t             lane_i,
  output pair_res_t         res_o
);

  logic [Lanes-1:0][CoordW-1:0] m_r, m_nxt;
  logic [Lanes-1:0][DistW-1:0]  sq_r;
  logic [2:0]                   a_ctl_r, b_ctl_r;
  pair_res_t                    res_r, res_nxt;
  logic [DistW:0]               d2_b, d2_a;

  // Fold the remainder into the minimum image magnitude
  always_comb begin
    logic [CoordW-1:0] bx, r, r2;
    for (int l = 0; l < Lanes; l++) begin
      bx = (l % 2 == 1) ? box_y : box_x;
      r  = lane_i.r[l];
      r2 = (lane_i.neg[l] && r != '0) ? bx - r : r;
      if (bx == '0) begin
        m_nxt[l] = r;
      end else if ({r2, 1'b0} > {1'b0, bx}) begin
        m_nxt[l] = bx - r2;
      end else begin
        m_nxt[l] = r2;
      end
    end
  end

  assign d2_b = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
  assign d2_a = {1'b0, sq_r[2]} + {1'b0, sq_r[3]};

  always_comb begin
    res_nxt       = '0;
    res_nxt.valid = b_ctl_r[2];
    res_nxt.skip  = b_ctl_r[1];
    res_nxt.last  = b_ctl_r[0];
    res_nxt.ovl_b = d2_b < {1'b0, core_dist_sq};
    res_nxt.con_b = !res_nxt.ovl_b && (d2_b < {1'b0, well_dist_sq});
    res_nxt.ovl_a = d2_a < {1'b0, core_dist_sq};
    res_nxt.con_a = !res_nxt.ovl_a && (d2_a < {1'b0, well_dist_sq});
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    for (int l = 0; l < Lanes; l++) begin
      sq_r[l] <= DistW'(m_r[l]) * DistW'(m_r[l]);
    end
    a_ctl_r <= {lane_i.valid, lane_i.skip, lane_i.last};
    b_ctl_r <= a_ctl_r;
    res_r   <= res_nxt;
    if (!rst_n) begin
      a_ctl_r[2]  <= 1'b0;
      b_ctl_r[2]  <= 1'b0;
      res_r.valid <= 1'b0;
    end
  end

  assign res_o = res_r;

endmodule

// File: rtl/core/square_well_metropolis_move.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+--------------------------------------------
// in_      | in_tvalid / in_tready    | tuser: action; tdata: index, load, disp, uniform
// out_     | out_tvalid / out_tready  | tdata: accepted, overlap, change, final x/y
// cfg_     | cfg_valid / cfg_ready    | cfg_index, cfg_data (always ready)
//
// A load beat goes from idle straight to the result state. A move passes accept,
// fetch and original read, n reads of the position store (one pair per cycle),
// drain (issue, difference, 24 remainder cells, 3 distance stages), up to k
// power steps for a rise of k contacts plus a decision, and the result beat.
// One beat is in flight at a time; in_tready is low until the result beat is
// taken, so a held out_tready adds its stall. Reset clears control and loads the
// configuration defaults; the store is undefined until loaded.
module square_well_metropolis_move
  import swm_pkg::*;
#(
  parameter int MAX_PARTICLES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // particle_index, load_x, load_y, disp_x, disp_y, uniform
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // accepted, hard_overlap, contact_change, final_x, final_y
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = ($clog2(MAX_PARTICLES + 1) > CntW) ? $clog2(MAX_PARTICLES + 1) : CntW;
  localparam int IW = (AW > 8) ? AW : 8;

  // unpack input beat
  logic [7:0]        in_idx;
  logic [CoordW-1:0] in_load_x, in_load_y, in_disp_x, in_disp_y;
  logic [ProbW-1:0]  in_uniform;
  assign in_idx     = in_tdata[7:0];
  assign in_load_x  = in_tdata[31:8];
  assign in_load_y  = in_tdata[55:32];
  assign in_disp_x  = in_tdata[79:56];
  assign in_disp_y  = in_tdata[103:80];
  assign in_uniform = in_tdata[119:104];

  // configuration
  logic [CoordW-1:0] box_x_r, box_y_r;
  logic [DistW-1:0]  core_r, well_r;
  logic [ProbW-1:0]  prob_r;
  logic [CntW-1:0]   npart_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= CoordW'(2621440);
      box_y_r <= CoordW'(2621440);
      core_r  <= DistW'(64'd17179869184);
      well_r  <= DistW'(64'd38654705664);
      prob_r  <= ProbW'(8869);
      npart_r <= CntW'(200);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOX_X:       box_x_r <= cfg_data[CoordW-1:0];
        CFG_BOX_Y:       box_y_r <= cfg_data[CoordW-1:0];
        CFG_CORE_DIST:   core_r  <= cfg_data;
        CFG_WELL_DIST:   well_r  <= cfg_data;
        CFG_ACCEPT_PROB: prob_r  <= cfg_data[ProbW-1:0];
        CFG_NUM_PART:    npart_r <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_used;
  assign n_used = (CW'(npart_r) > CW'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(npart_r);

  // position store
  logic [CoordW-1:0] mem_x [MAX_PARTICLES];
  logic [CoordW-1:0] mem_y [MAX_PARTICLES];
  logic [CoordW-1:0] rdx_r, rdy_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CoordW-1:0] wr_x, wr_y;
  logic              wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rdx_r <= mem_x[rd_addr];
    rdy_r <= mem_y[rd_addr];
  end

  // move context
  state_t            state_r, state_nxt;
  logic [IW-1:0]     idx_r;
  logic [CoordW-1:0] disp_x_r, disp_y_r, ox_r, oy_r, nx_r, ny_r;
  logic [ProbW-1:0]  uni_r;
  logic [CW-1:0]     j_r;
  logic              ovl_b_r, ovl_a_r;
  logic [CntW-1:0]   cnt_b_r, cnt_a_r;
  logic [ProbW:0]    q_r;
  logic [CntW-1:0]   k_r;
  logic              iss_v_r, iss_skip_r, iss_last_r;
  logic [63:0]       out_r, out_nxt;
  logic              out_load;

  function automatic logic [CoordW-1:0] wrap_coord(
    input logic [CoordW-1:0] c,
    input logic [CoordW-1:0] disp,
    input logic [CoordW-1:0] box
  );
    logic signed [CoordW+2:0] v;
    v = $signed({3'b000, c}) + $signed({{3{disp[CoordW-1]}}, disp});
    if (v < 0) begin
      v = v + $signed({3'b000, box});
    end else if (v > $signed({3'b000, box})) begin
      v = v - $signed({3'b000, box});
    end
    if (v < 0) begin
      return '0;
    end else if (v > $signed({3'b000, {CoordW{1'b1}}})) begin
      return '1;
    end
    return v[CoordW-1:0];
  endfunction

  // pair front end: signed difference per lane
  lane_t lane0_r;
  lane_t chain [RemSteps+1];
  pair_res_t res;

  always_ff @(posedge clk) begin
    logic [CoordW-1:0] a, b;
    for (int l = 0; l < Lanes; l++) begin
      case (l)
        0:       a = ox_r;
        1:       a = oy_r;
        2:       a = nx_r;
        default: a = ny_r;
      endcase
      b = (l % 2 == 1) ? rdy_r : rdx_r;
      lane0_r.neg[l] <= a < b;
      lane0_r.r[l]   <= (a < b) ? b - a : a - b;
    end
    lane0_r.skip  <= iss_skip_r;
    lane0_r.last  <= iss_last_r;
    lane0_r.valid <= rst_n ? iss_v_r : 1'b0;
  end

  assign chain[0] = lane0_r;

  for (genvar i = 0; i < RemSteps; i++) begin : g_rem
    swm_rem_cell #(.SHIFT(RemSteps - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .box_x  (box_x_r),
      .box_y  (box_y_r),
      .lane_i (chain[i]),
      .lane_o (chain[i+1])
    );
  end

  swm_dist_cell u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .box_x        (box_x_r),
    .box_y        (box_y_r),
    .core_dist_sq (core_r),
    .well_dist_sq (well_r),
    .lane_i       (chain[RemSteps]),
    .res_o        (res)
  );

  // decision terms
  logic signed [ChgW-1:0] chg;
  logic                   pow_busy, take;
  logic [ProbW*2:0]       q_prod;
  assign chg      = $signed({1'b0, cnt_a_r}) - $signed({1'b0, cnt_b_r});
  assign q_prod   = (ProbW*2+1)'(q_r) * (ProbW*2+1)'(prob_r);
  assign pow_busy = !ovl_a_r && !ovl_b_r && (chg > 0) && (k_r < chg[CntW-1:0]) && (q_r != '0);
  assign take     = !ovl_a_r && (ovl_b_r || chg <= 0 || {1'b0, uni_r} < q_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser && (CW'(in_idx) < CW'(MAX_PARTICLES))) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_FETCH: state_nxt = S_ORIG;
      S_ORIG:  state_nxt = (CW'(idx_r) < n_used) ? S_SWEEP : S_OUT;
      S_SWEEP: if (j_r == n_used - 1'b1) state_nxt = S_DRAIN;
      S_DRAIN: if (res.valid && res.last) state_nxt = S_POWER;
      S_POWER: if (!pow_busy) state_nxt = S_OUT;
      S_OUT:   if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs, store write and result word
  always_comb begin
    in_tready = (state_r == S_IDLE);
    rd_addr   = (state_r == S_SWEEP) ? j_r[AW-1:0] : idx_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_x      = nx_r;
    wr_y      = ny_r;
    out_load  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        wr_addr = AW'(in_idx);
        wr_x    = in_load_x;
        wr_y    = in_load_y;
        if (in_tvalid && !in_tuser && (CW'(in_idx) < CW'(MAX_PARTICLES))) begin
          wr_en   = 1'b1;
          out_nxt = {4'b0, in_load_y, in_load_x, ChgW'(0), 1'b0, 1'b1};
        end
        out_load = in_tvalid;
      end
      S_ORIG: begin
        out_load = 1'b1;
        out_nxt  = {4'b0, rdy_r, rdx_r, ChgW'(0), 1'b0, 1'b0};
      end
      S_POWER: begin
        if (!pow_busy) begin
          out_load = 1'b1;
          wr_en    = take;
          if (take) begin
            out_nxt = {4'b0, ny_r, nx_r, chg, ovl_a_r, 1'b1};
          end else begin
            out_nxt = {4'b0, oy_r, ox_r, chg, ovl_a_r, 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      idx_r    <= IW'(in_idx);
      disp_x_r <= in_disp_x;
      disp_y_r <= in_disp_y;
      uni_r    <= in_uniform;
    end
    if (state_r == S_ORIG) begin
      ox_r    <= rdx_r;
      oy_r    <= rdy_r;
      nx_r    <= wrap_coord(rdx_r, disp_x_r, box_x_r);
      ny_r    <= wrap_coord(rdy_r, disp_y_r, box_y_r);
      j_r     <= '0;
      ovl_b_r <= 1'b0;
      ovl_a_r <= 1'b0;
      cnt_b_r <= '0;
      cnt_a_r <= '0;
      q_r     <= {1'b1, {ProbW{1'b0}}};
      k_r     <= '0;
    end
    if (state_r == S_SWEEP) begin
      j_r <= j_r + 1'b1;
    end
    // accumulate pair results; the moving disk itself is skipped
    if (res.valid && !res.skip) begin
      ovl_b_r <= ovl_b_r | res.ovl_b;
      ovl_a_r <= ovl_a_r | res.ovl_a;
      cnt_b_r <= cnt_b_r + CntW'(res.con_b);
      cnt_a_r <= cnt_a_r + CntW'(res.con_a);
    end
    if (state_r == S_POWER && pow_busy) begin
      q_r <= q_prod[ProbW*2:ProbW];
      k_r <= k_r + 1'b1;
    end
    iss_skip_r <= (j_r == CW'(idx_r));
    iss_last_r <= (j_r == n_used - 1'b1);
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_v_r <= (state_r == S_SWEEP);
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_r;

  // checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while a result waits");
  a_no_overlap_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("overlapping move accepted");
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (j_r < n_used)) else $error("sweep past particle count");
  a_pow_only_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POWER && pow_busy) |-> (chg > 0)) else $error("power step without rise");

endmodule

// File: tb/square_well_metropolis_move_checker.sv
`default_nettype none

module square_well_metropolis_move_checker
  import swm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [119:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [63:0]  out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data,
  output int                fail_count,
  output int                results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth = 256;

  typedef struct {
    logic               accepted;
    logic               hard_overlap;
    logic [ChgW-1:0]    contact_change;
    logic [CoordW-1:0]  final_x;
    logic [CoordW-1:0]  final_y;
  } move_result_t;

  logic [CoordW-1:0] box_x_q, box_y_q;
  logic [DistW-1:0]  core_sq_q, well_sq_q;
  logic [ProbW-1:0]  prob_q;
  logic [CntW-1:0]   count_q;
  logic [CoordW-1:0] disk_x [StoreDepth];
  logic [CoordW-1:0] disk_y [StoreDepth];

  move_result_t awaited_results[$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
    box_x_q    = 24'd2621440;
    box_y_q    = 24'd2621440;
    core_sq_q  = 48'd17179869184;
    well_sq_q  = 48'd38654705664;
    prob_q     = 16'd8869;
    count_q    = 9'd200;
    foreach (disk_x[i]) begin
      disk_x[i] = '0;
      disk_y[i] = '0;
    end
  end

  function automatic longint unsigned image_sq(longint a, longint b, longint unsigned span);
    longint d, r, bx;
    longint unsigned m;
    d = a - b;
    if (span != 0) begin
      bx = longint'(span);
      r = d % bx;
      if (r < 0) r += bx;
      if (2 * r > bx) r -= bx;
      d = r;
    end
    m = (d < 0) ? longint'(-d) : longint'(d);
    return m * m;
  endfunction

  // Contacts of disk self at (x, y) against all others in use
  function automatic int count_contacts(int self, int n, longint x, longint y,
                                        output bit hit_core);
    int contacts;
    longint unsigned d2;
    contacts = 0;
    hit_core = 0;
    for (int i = 0; i < n; i++) begin
      if (i != self) begin
        d2 = image_sq(x, longint'(disk_x[i]), box_x_q) + image_sq(y, longint'(disk_y[i]), box_y_q);
        if (d2 < core_sq_q) hit_core = 1;
        else if (d2 < well_sq_q) contacts++;
      end
    end
    return contacts;
  endfunction

  function automatic logic [CoordW-1:0] wrap_axis(longint c, longint disp, longint span);
    longint v;
    v = c + disp;
    if (v < 0) v += span;
    else if (v > span) v -= span;
    if (v < 0) v = 0;
    if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
    return v[CoordW-1:0];
  endfunction

  function automatic move_result_t predict_move(logic action, logic [119:0] d);
    move_result_t res;
    int idx, n, contacts_old, contacts_new, change;
    bit core_before, core_after, take;
    logic [CoordW-1:0] nx, ny;
    longint unsigned q;
    idx = int'(d[7:0]);
    n   = (count_q > StoreDepth) ? StoreDepth : int'(count_q);
    res = '{accepted: 0, hard_overlap: 0, contact_change: '0, final_x: '0, final_y: '0};
    if (action == 1'b0) begin
      disk_x[idx] = d[31:8];
      disk_y[idx] = d[55:32];
      res.final_x  = d[31:8];
      res.final_y  = d[55:32];
      res.accepted = 1;
    end else begin
      res.final_x = disk_x[idx];
      res.final_y = disk_y[idx];
      if (idx < n) begin
        contacts_old = count_contacts(idx, n, disk_x[idx], disk_y[idx], core_before);
        nx = wrap_axis(disk_x[idx], longint'(signed'(d[79:56])), longint'(box_x_q));
        ny = wrap_axis(disk_y[idx], longint'(signed'(d[103:80])), longint'(box_y_q));
        contacts_new = count_contacts(idx, n, nx, ny, core_after);
        change = contacts_new - contacts_old;
        res.contact_change = change[ChgW-1:0];
        res.hard_overlap   = core_after;
        if (core_after) take = 0;
        else if (core_before || change <= 0) take = 1;
        else begin
          q = 65536;
          for (int k = 0; k < change && q != 0; k++) q = (q * prob_q) >> 16;
          take = longint'(d[119:104]) < q;
        end
        if (take) begin
          disk_x[idx] = nx;
          disk_y[idx] = ny;
          res.final_x  = nx;
          res.final_y  = ny;
          res.accepted = 1;
        end
      end
    end
    return res;
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    move_result_t exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BOX_X:       box_x_q   = cfg_data[CoordW-1:0];
          CFG_BOX_Y:       box_y_q   = cfg_data[CoordW-1:0];
          CFG_CORE_DIST:   core_sq_q = cfg_data;
          CFG_WELL_DIST:   well_sq_q = cfg_data;
          CFG_ACCEPT_PROB: prob_q    = cfg_data[ProbW-1:0];
          CFG_NUM_PART:    count_q   = cfg_data[CntW-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing expected: %0h", out_tdata);
          fail_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          compare_field("accepted", exp_r.accepted, out_tdata[0]);
          compare_field("hard_overlap", exp_r.hard_overlap, out_tdata[1]);
          compare_field("contact_change", exp_r.contact_change, out_tdata[11:2]);
          compare_field("final_x", exp_r.final_x, out_tdata[35:12]);
          compare_field("final_y", exp_r.final_y, out_tdata[59:36]);
        end
      end
      if (in_tvalid && in_tready) awaited_results.push_back(predict_move(in_tuser, in_tdata));
      results_pending = awaited_results.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/square_well_metropolis_move_tb.sv
`default_nettype none

module square_well_metropolis_move_tb;
  import swm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Moves cost more with n and k; give every beat room to spare
  localparam int CycleLimit = 3_000_000;
  localparam int HoldOff    = 600;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;   // particle_index, load_x, load_y, disp_x, disp_y, uniform
  logic         in_tuser = 1'b0; // action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;       // accepted, hard_overlap, contact_change, final_x, final_y
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  int fail_count, results_pending;
  int cycle_count = 0;
  bit calm = 0;        // no idling on either side while set
  bit want_hold = 0;   // ask the receiver for one long hold-off
  bit hold_done = 0;

  // Stimulus-side shadow of the geometry, used only to shape random beats
  int unsigned cur_box_x, cur_box_y, cur_n;

  always #5 clk = ~clk;

  square_well_metropolis_move uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  square_well_metropolis_move_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .results_pending
  );

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
        hold_done = 1;
      end
      out_tready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // Write one register; cfg_valid stays up across a burst of writes
  task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(int unsigned bx, int unsigned by, logic [47:0] core,
                              logic [47:0] well, int unsigned p, int unsigned n);
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_CORE_DIST, core);
    write_reg(CFG_WELL_DIST, well);
    write_reg(CFG_ACCEPT_PROB, p);
    write_reg(CFG_NUM_PART, n);
    cfg_valid <= 1'b0;
    cur_box_x = bx;
    cur_box_y = by;
    cur_n     = (n > 256) ? 256 : n;
  endtask

  // Offer one beat; in_tvalid is only dropped during an idle gap
  task automatic send_beat(bit action, int unsigned idx, int unsigned lx, int unsigned ly,
                           int unsigned dx, int unsigned dy, int unsigned u);
    while (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {u[15:0], dy[23:0], dx[23:0], ly[23:0], lx[23:0], idx[7:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_load(int unsigned idx, int unsigned lx, int unsigned ly);
    send_beat(1'b0, idx, lx, ly, $urandom, $urandom, $urandom);
  endtask

  task automatic send_move(int unsigned idx, int unsigned dx, int unsigned dy, int unsigned u);
    send_beat(1'b1, idx, $urandom, $urandom, dx, dy, u);
  endtask

  // Coordinate mostly inside the box, sometimes anywhere in 24 bits
  function automatic int unsigned pick_coord(int unsigned span);
    if ($urandom_range(9) < 8) return $urandom_range(span - 1, 0) & 24'hFF_FFFF;
    return $urandom & 24'hFF_FFFF;
  endfunction

  // Displacement mostly a small step, sometimes any 24-bit value
  function automatic int unsigned pick_step(int unsigned span);
    int unsigned reach;
    int s;
    reach = (span >> 3) + 1;
    if (reach > 24'h7F_FFFF) reach = 24'h7F_FFFF;
    if ($urandom_range(9) < 2) return $urandom & 24'hFF_FFFF;
    s = $urandom_range(reach, 0);
    if ($urandom_range(1)) s = -s;
    return s & 24'hFF_FFFF;
  endfunction

  task automatic random_beats(int count);
    int unsigned idx;
    repeat (count) begin
      if ($urandom_range(99) < 15) begin
        send_load($urandom_range(255), pick_coord(cur_box_x), pick_coord(cur_box_y));
      end else begin
        idx = ($urandom_range(9) < 9) ? $urandom_range(cur_n - 1) : $urandom_range(255);
        send_move(idx, pick_step(cur_box_x), pick_step(cur_box_y), $urandom & 16'hFFFF);
      end
    end
  endtask

  // Let every result drain before touching the registers again
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default geometry: box 40x40, core 2, well 3
    program_regs(24'd2621440, 24'd2621440, 48'd17179869184, 48'd38654705664, 8869, 200);

    // Fill the whole store so no move ever reads an unwritten disk
    for (int i = 0; i < 256; i++) send_load(i, pick_coord(cur_box_x), pick_coord(cur_box_y));

    // Directed: coincident disks, overlap removed by a far move
    send_load(1, 24'h05_0000, 24'h05_0000);
    send_load(0, 24'h05_0000, 24'h05_0000);
    send_move(0, 24'h0A_0000, 24'h0A_0000, 16'h0000);
    // Move back onto disk 1: overlap made, rejected
    send_move(0, 24'hF6_0000, 24'hF6_0000, 16'hFFFF);
    // Contact rise, both uniform extremes
    send_load(2, 24'h0A_8000, 24'h0A_0000);
    send_move(2, 24'hFE_0000, 24'h00_0000, 16'h0000);
    send_move(2, 24'h02_0000, 24'h00_0000, 16'hFFFF);
    // Largest and smallest displacements, zero displacement
    send_move(3, 24'h7F_FFFF, 24'h80_0000, 16'h1234);
    send_move(4, 24'h80_0000, 24'h7F_FFFF, 16'h8000);
    send_move(5, 24'h00_0000, 24'h00_0000, 16'h0001);
    // Coordinate extremes on a load, wrap below zero and past the box
    send_load(6, 24'h00_0000, 24'hFF_FFFF);
    send_move(6, 24'hFF_0000, 24'h01_0000, 16'h4000);
    send_load(7, 24'hFF_FFFF, 24'h00_0000);
    send_move(7, 24'h01_0000, 24'hFF_0000, 16'h4000);
    // Index at or above the particle count, then the last index below it
    send_move(200, 24'h01_0000, 24'h01_0000, 16'h0000);
    send_move(255, 24'h01_0000, 24'h01_0000, 16'h0000);
    send_load(255, 24'h12_3456, 24'h65_4321);
    send_move(199, 24'h00_8000, 24'h00_8000, 16'hFFFF);

    random_beats(120);
    wait_drained();

    // Tiny crowd of two, full acceptance probability
    program_regs(24'h0A_0000, 24'h14_0000, 48'h1_0000_0000, 48'h2_4000_0000, 16'hFFFF, 2);
    random_beats(60);
    wait_drained();

    // Largest box, no core, well covers everything, zero probability, all disks
    program_regs(24'hFF_FFFF, 24'hFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF, 16'h0000, 256);
    random_beats(100);
    wait_drained();

    // Narrowest box; clean run with no idling, then the long hold-off
    program_regs(24'd1, 24'h05_0000, 48'h0000_4000_0000, 48'h1_0000_0000, 40000, 64);
    calm = 1;
    random_beats(60);
    calm = 0;
    want_hold = 1;
    random_beats(140);
    wait_drained();

    // Everything overlaps the core
    program_regs(24'h20_0000, 24'h20_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h8000, 150);
    random_beats(40);
    wait_drained();

    // Back to a dense default-like box
    program_regs(24'd2621440, 24'd2621440, 48'd17179869184, 48'd38654705664, 16'h8000, 150);
    random_beats(80);

    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
